// ===== hw/rtl/vps_pkg.sv =====
`default_nettype none

package vps_pkg;

  localparam int VALVES           = 4;
  localparam int OVERCURRENT_HOLD = 12;
  localparam int IDX_W            = (VALVES > 1) ? $clog2(VALVES) : 1;
  localparam int OC_W             = $clog2(OVERCURRENT_HOLD + 2);

  localparam int POS_LIMIT       = 100;
  localparam int MOVE_LIMIT_MAX  = 2000;
  localparam int HOME_LIMIT_MAX  = 1000;
  localparam int HOME_WRAP_POS   = 99;
  localparam int TICK_RESET      = 100;

  localparam logic signed [1:0] DIR_OPEN  = 2'sb01;
  localparam logic signed [1:0] DIR_STOP  = 2'sb00;
  localparam logic signed [1:0] DIR_CLOSE = 2'sb11;

  typedef enum logic [1:0] {
    OP_CONTROL = 2'd0,
    OP_MOVE    = 2'd1,
    OP_HOME    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HOME = 2'd1,
    MODE_MOVE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_HOMING = 3'd1,
    ERR_VALVE  = 3'd2,
    ERR_VALUE  = 3'd3,
    ERR_NOREF  = 3'd4
  } err_e;

  // Architectural state of the sequencer, apart from the tick period register.
  typedef struct packed {
    mode_e                   mode;
    logic [2:0]              sel;
    logic [VALVES-1:0][6:0]  target;
    logic [VALVES-1:0][6:0]  position;
    logic [VALVES-1:0][10:0] limit;
    logic [OC_W-1:0]         oc_count;
    logic [15:0]             tick_ref;
    logic [VALVES-1:0]       ref_mask;
    logic [VALVES-1:0]       active;
    logic                    move;
    logic                    home;
    logic                    overcurrent;
    logic signed [1:0]       dir;
  } vps_state_t;

  // Result word; the last member sits in the lowest bits.
  typedef struct packed {
    err_e              command_error;
    logic              overcurrent_error;
    logic              home_pending;
    logic              move_pending;
    logic [3:0]        active_mask;
    logic [3:0]        reference_mask;
    logic [6:0]        valve_position;
    logic [2:0]        selected_valve;
    logic signed [1:0] direction;
    logic [1:0]        mode;
  } vps_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vps_step.sv =====
`default_nettype none

module vps_step
  import vps_pkg::*;
(
  input  vps_state_t         state_i,
  input  op_e                op_i,
  input  logic [7:0]         valve_i,
  input  logic [7:0]         target_position_i,
  input  logic signed [15:0] current_limit_i,
  input  logic signed [15:0] current_sample_i,
  input  logic [15:0]        time_ms_i,
  input  logic [15:0]        tick_period_i,
  output vps_state_t         state_o,
  output vps_result_t        result_o
);

  vps_state_t         st;
  err_e               err;
  logic [IDX_W-1:0]   vidx;
  logic [VALVES-1:0]  vbit;
  logic               sel_ok;
  logic [IDX_W-1:0]   idx;
  logic [VALVES-1:0]  sbit;
  logic [15:0]        elapsed;
  logic               tick;
  logic               oc_hit;
  logic [OC_W-1:0]    oc_inc;
  logic               oc_trip;
  logic [6:0]         cur_pos;
  logic [6:0]         cur_tgt;
  logic signed [1:0]  move_dir;

  assign elapsed = time_ms_i - state_i.tick_ref;
  assign tick    = elapsed > tick_period_i;
  assign vidx    = IDX_W'(valve_i - 8'd1);
  assign vbit    = VALVES'(1) << vidx;

  always_comb begin
    st       = state_i;
    err      = ERR_OK;
    sel_ok   = 1'b0;
    idx      = '0;
    sbit     = '0;
    oc_hit   = 1'b0;
    oc_inc   = '0;
    oc_trip  = 1'b0;
    cur_pos  = '0;
    cur_tgt  = '0;
    move_dir = DIR_STOP;

    // Command phase.
    unique case (op_i)
      OP_MOVE: begin
        if (st.home) begin
          err = ERR_HOMING;
        end else if (valve_i == 8'd0) begin
          st.move = 1'b0;
        end else if (valve_i > 8'(VALVES)) begin
          err = ERR_VALVE;
        end else begin
          st.sel = 3'(valve_i);
          if (target_position_i > 8'(POS_LIMIT)) begin
            err = ERR_VALUE;
          end else begin
            st.target[vidx] = target_position_i[6:0];
            if (current_limit_i < 16'sd1 || current_limit_i > 16'(MOVE_LIMIT_MAX)) begin
              err = ERR_VALUE;
            end else begin
              st.limit[vidx] = current_limit_i[10:0];
              if ((st.ref_mask & vbit) == '0) begin
                err = ERR_NOREF;
              end else begin
                st.active = vbit;
                st.move   = 1'b1;
              end
            end
          end
        end
      end
      OP_HOME: begin
        if (valve_i == 8'd0) begin
          st.ref_mask = '0;
        end else if (valve_i > 8'(VALVES)) begin
          err = ERR_VALVE;
        end else begin
          st.sel = 3'(valve_i);
          if (current_limit_i < 16'sd1 || current_limit_i > 16'(HOME_LIMIT_MAX)) begin
            err = ERR_VALUE;
          end else begin
            st.limit[vidx] = current_limit_i[10:0];
            st.active      = vbit;
            st.home        = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    sel_ok  = (st.sel != 3'd0) && (st.sel <= 3'(VALVES));
    idx     = IDX_W'(st.sel - 3'd1);
    sbit    = VALVES'(1) << idx;
    cur_pos = st.position[idx];
    cur_tgt = st.target[idx];

    // Overcurrent detection against the limit of the selected valve.
    oc_hit  = $signed(current_sample_i) > $signed({5'b0, st.limit[idx]});
    oc_inc  = (st.oc_count <= OC_W'(OVERCURRENT_HOLD)) ? st.oc_count + OC_W'(1)
                                                       : st.oc_count;
    oc_trip = oc_hit && (oc_inc > OC_W'(OVERCURRENT_HOLD));

    // Control phase.
    if (state_i.mode == MODE_MOVE && sel_ok) begin
      if (cur_tgt > cur_pos) begin
        move_dir = DIR_OPEN;
      end else if (cur_tgt < cur_pos) begin
        move_dir = DIR_CLOSE;
      end else begin
        move_dir  = DIR_STOP;
        st.move   = 1'b0;
        st.active = '0;
        st.mode   = MODE_IDLE;
      end
      st.oc_count = oc_hit ? oc_inc : '0;
      if (oc_trip) begin
        move_dir       = DIR_STOP;
        st.overcurrent = 1'b1;
        st.mode        = MODE_IDLE;
        st.move        = 1'b0;
      end
      st.dir = move_dir;
      if (tick) begin
        st.position[idx] = cur_pos + {{5{move_dir[1]}}, move_dir};
        st.tick_ref      = time_ms_i;
      end
    end else if (state_i.mode == MODE_HOME || state_i.mode == MODE_MOVE) begin
      st.dir = DIR_STOP;
      if (!sel_ok) begin
        // The job has lost its valve: cancel it.
        st.home = 1'b0;
        if (state_i.mode == MODE_MOVE) begin
          st.move = 1'b0;
        end
        st.active = '0;
        st.mode   = MODE_IDLE;
        if (tick) begin
          st.tick_ref = time_ms_i;
        end
      end else begin
        st.oc_count = oc_hit ? oc_inc : '0;
        if (oc_trip) begin
          // Hard stop reached: this is the closed reference.
          st.overcurrent   = 1'b1;
          st.position[idx] = '0;
          st.mode          = MODE_IDLE;
          st.home          = 1'b0;
          st.ref_mask      = st.ref_mask | sbit;
        end else begin
          st.dir = DIR_CLOSE;
          if (tick) begin
            st.position[idx] = (cur_pos > 7'd0) ? cur_pos - 7'd1 : 7'(HOME_WRAP_POS);
          end
        end
        if (tick) begin
          st.tick_ref = time_ms_i;
        end
      end
    end else begin
      st.dir      = DIR_STOP;
      st.oc_count = '0;
      if (sel_ok) begin
        if (st.home) begin
          st.mode = MODE_HOME;
        end else if (st.move) begin
          st.mode = MODE_MOVE;
        end
      end
      st.tick_ref = time_ms_i;
    end
  end

  assign state_o = st;

  always_comb begin
    result_o.mode              = st.mode;
    result_o.direction         = st.dir;
    result_o.selected_valve    = st.sel;
    result_o.valve_position    = sel_ok ? st.position[idx] : 7'd0;
    result_o.reference_mask    = st.ref_mask;
    result_o.active_mask       = st.active;
    result_o.move_pending      = st.move;
    result_o.home_pending      = st.home;
    result_o.overcurrent_error = st.overcurrent;
    result_o.command_error     = err;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vps_skid.sv =====
`default_nettype none

module vps_skid
  import vps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vps_result_t in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output vps_result_t out_data_o
);

  logic        out_valid_q;
  logic        skid_valid_q;
  vps_result_t out_data_q;
  vps_result_t skid_data_q;
  logic        push;
  logic        pop;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign push        = in_valid_i && !skid_valid_q;
  assign pop         = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_data_q <= in_data_i;
      end else begin
        skid_data_q <= in_data_i;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while the output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && out_data_q == $past(out_data_q)))
    else $error("stalled result word was lost or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (out_valid_q && !skid_valid_q))
    else $error("skid word was not moved to the output register");

endmodule

`default_nettype wire

// ===== hw/rtl/valve_position_sequencer_core.sv =====
// Each result word is registered into the output buffer when its command word is taken.
// One word per cycle unless the output buffer is full; the state update is combinational.
// A two-entry output buffer lets the next word enter while a result waits.
// Reset (rst_ni low, asynchronous): idle, no valve, all stores, masks and flags zero,
// tick period 100 ms; the block is ready for words as soon as reset is released.
`default_nettype none

module valve_position_sequencer_core
  import vps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, lowest bits first: valve[7:0], target_position[15:8],
  // current_limit[31:16], current_sample[47:32], time_ms[63:48]
  input  logic [63:0] s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Status words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, lowest bits first: mode[1:0], direction[3:2], selected_valve[6:4],
  // valve_position[13:7], reference_mask[17:14], active_mask[21:18],
  // move_pending[22], home_pending[23], overcurrent_error[24],
  // command_error[27:25], zero[31:28]
  output logic [31:0] m_axis_tdata,
  // Tick period register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  vps_state_t  state_q;
  vps_state_t  state_d;
  vps_result_t result;
  vps_result_t out_word;
  logic [15:0] tick_period_q;
  logic        accept;

  // The period register is always writable; the host must write it only while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= 16'(TICK_RESET);
    end else if (cfg_valid_i) begin
      tick_period_q <= cfg_data_i;
    end
  end

  // All command decoding and the control cycle happen in one pass.
  vps_step u_step (
    .state_i           (state_q),
    .op_i              (op_e'(s_axis_tuser)),
    .valve_i           (s_axis_tdata[7:0]),
    .target_position_i (s_axis_tdata[15:8]),
    .current_limit_i   (s_axis_tdata[31:16]),
    .current_sample_i  (s_axis_tdata[47:32]),
    .time_ms_i         (s_axis_tdata[63:48]),
    .tick_period_i     (tick_period_q),
    .state_o           (state_d),
    .result_o          (result)
  );

  assign accept = s_axis_tvalid && s_axis_tready;

  // The state only advances when a word is taken, so a stall freezes the sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Output register plus one skid entry decouples the two sides.
  vps_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_word)
  );

  assign m_axis_tdata = {4'b0, out_word};

  // A running job always has a valid valve selected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode != MODE_IDLE) |->
      (state_q.sel != 3'd0 && state_q.sel <= 3'(VALVES)))
    else $error("job running without a valid valve");

  // The motor never drives while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_IDLE) |-> (state_q.dir == DIR_STOP))
    else $error("motor driven in idle mode");

  // The overcurrent counter saturates one past the hold time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.oc_count <= OC_W'(OVERCURRENT_HOLD + 1))
    else $error("overcurrent counter ran past saturation");

  // Without an accepted word the state must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(state_q))
    else $error("state changed without an accepted word");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import vps_pkg::*;

  // The command field has one unused code, which the block treats as a control cycle.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int PHASE_WORDS = 175;
  localparam int SEQ_CAP = 40;
  localparam int STALL_CYCLES = 80;

  // Predicts the status word for every accepted command word and holds the
  // predictions until the block delivers them.
  class valve_status_scoreboard;
    mode_e             mode;
    logic [2:0]        sel;
    logic [6:0]        target [VALVES];
    logic [6:0]        position [VALVES];
    logic [10:0]       limit [VALVES];
    int unsigned       oc_count;
    logic [15:0]       tick_ref;
    logic [VALVES-1:0] ref_mask;
    logic [VALVES-1:0] active;
    bit                move;
    bit                home;
    bit                oc_flag;
    logic signed [1:0] dir;
    logic [15:0]       tick_period;
    vps_result_t       expected_status_q [$];
    int                errors;

    function new();
      mode = MODE_IDLE;
      sel = '0;
      for (int i = 0; i < VALVES; i++) begin
        target[i] = '0;
        position[i] = '0;
        limit[i] = '0;
      end
      oc_count = 0;
      tick_ref = '0;
      ref_mask = '0;
      active = '0;
      move = 1'b0;
      home = 1'b0;
      oc_flag = 1'b0;
      dir = DIR_STOP;
      tick_period = 16'(TICK_RESET);
      errors = 0;
    endfunction

    function void set_tick_period(logic [15:0] period);
      tick_period = period;
    endfunction

    function bit sel_ok();
      return (sel >= 1) && (sel <= VALVES);
    endfunction

    // True once the current has stayed above the limit long enough to stop the motor.
    function bit overcurrent_trip(logic signed [15:0] sample);
      int s;
      int l;
      s = sample;
      l = limit[sel - 1];
      if (s > l) begin
        if (oc_count <= OVERCURRENT_HOLD) oc_count++;
        if (oc_count > OVERCURRENT_HOLD) begin
          dir = DIR_STOP;
          oc_flag = 1'b1;
          return 1'b1;
        end
      end else begin
        oc_count = 0;
      end
      return 1'b0;
    endfunction

    function void note_command(logic [1:0] op, logic [7:0] valve, logic [7:0] pos,
                               logic signed [15:0] lim, logic signed [15:0] sample,
                               logic [15:0] now);
      err_e        err;
      bit          tick;
      bit          done;
      int          idx;
      vps_result_t r;
      err = ERR_OK;
      if (op == OP_MOVE) begin
        if (home) err = ERR_HOMING;
        else if (valve == 0) move = 1'b0;
        else if (valve > VALVES) err = ERR_VALVE;
        else begin
          // The selection sticks even when a later check rejects the command.
          sel = valve[2:0];
          if (pos > POS_LIMIT) err = ERR_VALUE;
          else begin
            target[valve - 1] = pos[6:0];
            if (lim < 1 || lim > MOVE_LIMIT_MAX) err = ERR_VALUE;
            else begin
              limit[valve - 1] = lim[10:0];
              if (!ref_mask[valve - 1]) err = ERR_NOREF;
              else begin
                active = '0;
                active[valve - 1] = 1'b1;
                move = 1'b1;
              end
            end
          end
        end
      end else if (op == OP_HOME) begin
        if (valve == 0) ref_mask = '0;
        else if (valve > VALVES) err = ERR_VALVE;
        else begin
          sel = valve[2:0];
          if (lim < 1 || lim > HOME_LIMIT_MAX) err = ERR_VALUE;
          else begin
            limit[valve - 1] = lim[10:0];
            active = '0;
            active[valve - 1] = 1'b1;
            home = 1'b1;
          end
        end
      end

      tick = 16'(now - tick_ref) > tick_period;
      idx = sel - 1;
      done = 1'b0;
      if (mode == MODE_MOVE && sel_ok()) begin
        if (target[idx] > position[idx]) dir = DIR_OPEN;
        else if (target[idx] < position[idx]) dir = DIR_CLOSE;
        else begin
          dir = DIR_STOP;
          move = 1'b0;
          active = '0;
          mode = MODE_IDLE;
        end
        if (overcurrent_trip(sample)) begin
          mode = MODE_IDLE;
          move = 1'b0;
        end
        if (tick) begin
          if (dir == DIR_OPEN) position[idx]++;
          else if (dir == DIR_CLOSE) position[idx]--;
          tick_ref = now;
        end
      end else if (mode != MODE_IDLE) begin
        dir = DIR_STOP;
        if (!sel_ok()) begin
          if (mode == MODE_MOVE) move = 1'b0;
          home = 1'b0;
          active = '0;
          mode = MODE_IDLE;
          if (tick) tick_ref = now;
        end else begin
          done = overcurrent_trip(sample);
          if (done) begin
            position[idx] = '0;
            mode = MODE_IDLE;
            home = 1'b0;
            ref_mask[idx] = 1'b1;
          end else begin
            dir = DIR_CLOSE;
          end
          // Closing past zero wraps the tracked position; completion never steps.
          if (tick) begin
            if (!done) position[idx] = (position[idx] > 7'd0) ? position[idx] - 7'd1
                                                              : 7'(HOME_WRAP_POS);
            tick_ref = now;
          end
        end
      end else begin
        dir = DIR_STOP;
        oc_count = 0;
        if (sel_ok()) begin
          if (home) mode = MODE_HOME;
          else if (move) mode = MODE_MOVE;
        end
        tick_ref = now;
      end

      r.mode = mode;
      r.direction = dir;
      r.selected_valve = sel;
      r.valve_position = sel_ok() ? position[idx] : 7'd0;
      r.reference_mask = ref_mask;
      r.active_mask = active;
      r.move_pending = move;
      r.home_pending = home;
      r.overcurrent_error = oc_flag;
      r.command_error = err;
      expected_status_q.push_back(r);
    endfunction

    function void check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_status(logic [31:0] word);
      vps_result_t want;
      vps_result_t got;
      if (expected_status_q.size() == 0) begin
        $error("status word %h arrived with no command outstanding", word);
        errors++;
        return;
      end
      want = expected_status_q.pop_front();
      got = vps_result_t'(word[27:0]);
      check_field("mode", want.mode, got.mode);
      check_field("direction", want.direction, got.direction);
      check_field("selected_valve", want.selected_valve, got.selected_valve);
      check_field("valve_position", want.valve_position, got.valve_position);
      check_field("reference_mask", want.reference_mask, got.reference_mask);
      check_field("active_mask", want.active_mask, got.active_mask);
      check_field("move_pending", want.move_pending, got.move_pending);
      check_field("home_pending", want.home_pending, got.home_pending);
      check_field("overcurrent_error", want.overcurrent_error, got.overcurrent_error);
      check_field("command_error", want.command_error, got.command_error);
      check_field("padding", 0, word[31:28]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  valve_status_scoreboard sb = new();

  // Idle percentages of each side, changed between phases by the stimulus.
  int send_idle_pct = 31;
  int recv_idle_pct = 52;
  // Cycles the status side still has to hold off; loaded once to fill the block.
  int stall_left = 0;
  int words_sent = 0;
  // Millisecond counter that the stimulus moves on and puts in the command words.
  logic [15:0] clock_ms = '0;

  always #1 clk_i = ~clk_i;

  valve_position_sequencer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Moves the millisecond counter on. Half of the steps cross the tick period so the
  // tracked position advances; others stay inside it, stand still or jump anywhere.
  function automatic logic [15:0] advance_ms();
    int unsigned p;
    p = sb.tick_period;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: clock_ms = 16'(clock_ms + p + 1 + $urandom_range(2));
      5, 6, 7:       clock_ms = 16'(clock_ms + $urandom_range(p));
      8:             ;
      default:       clock_ms = 16'($urandom);
    endcase
    return clock_ms;
  endfunction

  // Draws a motor current around the limit of the selected valve; over_pct is the
  // share of samples above it.
  function automatic logic [15:0] current_sample(int over_pct);
    int lim;
    int roll;
    lim = sb.sel_ok() ? sb.limit[sb.sel - 1] : 0;
    roll = $urandom_range(99);
    if (roll < over_pct) return 16'($urandom_range(lim + 1, 32767));
    if (roll < over_pct + 5) return 16'(lim);
    return 16'(int'($urandom_range(lim + 32768)) - 32768);
  endfunction

  // Mostly legal limits with both edges favored, plus the odd rejected one.
  function automatic logic [15:0] pick_limit(int hi);
    case ($urandom_range(19))
      0, 1:    return 16'(1);
      2, 3:    return 16'(hi);
      4:       return 16'($urandom_range(hi + 1, 32767));
      5:       return 16'(-int'($urandom_range(32768)));
      default: return 16'($urandom_range(1, hi));
    endcase
  endfunction

  // Offers one command word, after a random gap, and records it once taken.
  task automatic send_command(input logic [1:0] op, input logic [7:0] valve,
                              input logic [7:0] pos, input logic signed [15:0] lim,
                              input logic signed [15:0] sample, input logic [15:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {now, sample, lim, pos, valve};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(op, valve, pos, lim, sample, now);
    words_sent++;
  endtask

  // Stops offering words and waits until every predicted status word is in.
  task automatic wait_for_status();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_tick_period(input logic [15:0] period);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= period;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_tick_period(period);
  endtask

  // Starts homing a valve and feeds control cycles, mostly above the limit, until
  // homing completes. Now and then a move command arrives and must be refused.
  task automatic home_valve(input int v);
    int n;
    send_command(OP_HOME, 8'(v), 8'($urandom), pick_limit(HOME_LIMIT_MAX), 16'($urandom),
                 advance_ms());
    n = 0;
    while (sb.home && n < SEQ_CAP) begin
      if ($urandom_range(9) == 0)
        send_command(OP_MOVE, 8'($urandom_range(VALVES + 1)), 8'($urandom), 16'($urandom),
                     current_sample(85), advance_ms());
      else
        send_command(OP_CONTROL, 8'($urandom), 8'($urandom), 16'($urandom),
                     current_sample(85), advance_ms());
      n++;
    end
  endtask

  // Moves a valve, homing it first if it has no reference. Half of the targets lie
  // close to the present position so the move finishes within a few ticks.
  task automatic move_valve(input int v);
    int n;
    int tgt;
    int over;
    if (!sb.ref_mask[v - 1]) home_valve(v);
    case ($urandom_range(9))
      0:       tgt = 0;
      1:       tgt = POS_LIMIT;
      2, 3:    tgt = $urandom_range(POS_LIMIT);
      4:       tgt = $urandom_range(POS_LIMIT + 1, 255);
      default: begin
        tgt = int'(sb.position[v - 1]) + int'($urandom_range(12)) - 6;
        if (tgt < 0) tgt = 0;
        if (tgt > POS_LIMIT) tgt = POS_LIMIT;
      end
    endcase
    // One move in ten runs into a sustained overcurrent.
    over = ($urandom_range(9) == 0) ? 90 : 6;
    send_command(OP_MOVE, 8'(v), 8'(tgt), pick_limit(MOVE_LIMIT_MAX), 16'($urandom),
                 advance_ms());
    n = 0;
    while ((sb.move || sb.mode != MODE_IDLE) && n < SEQ_CAP) begin
      send_command(OP_CONTROL, 8'($urandom), 8'($urandom), 16'($urandom),
                   current_sample(over), advance_ms());
      n++;
    end
  endtask

  // Status side: checks every word taken and decides tready for the next cycle.
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Command side: reset, a directed opening, then four random phases, each with
  // its own tick period; phases 1 and 2 also set their own idling pattern.
  initial begin
    int          mark;
    int          n;
    logic [15:0] period;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing selected yet, so the position reads zero; the spare op code only
    // runs a control cycle. Field extremes go in here as well.
    send_command(OP_CONTROL, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    send_command(OP_SPARE, 8'hFF, 8'hFF, 16'h7FFF, 16'h8000, 16'hFFFF);
    // A move with no valve only clears the move job.
    send_command(OP_MOVE, 8'd0, 8'd50, 16'd100, 16'd0, 16'd10);
    send_command(OP_MOVE, 8'(VALVES + 1), 8'd50, 16'd100, 16'd0, 16'd20);
    send_command(OP_MOVE, 8'hFF, 8'd50, 16'd100, 16'd0, 16'd30);
    // Value checks: the valve stays selected and anything stored before the
    // failing check is kept.
    send_command(OP_MOVE, 8'd1, 8'(POS_LIMIT + 1), 16'd100, 16'd0, 16'd40);
    send_command(OP_MOVE, 8'd1, 8'hFF, 16'd100, 16'd0, 16'd41);
    send_command(OP_MOVE, 8'd1, 8'(POS_LIMIT), 16'd0, 16'd0, 16'd42);
    send_command(OP_MOVE, 8'd1, 8'd0, 16'h8000, 16'd0, 16'd43);
    send_command(OP_MOVE, 8'd1, 8'd0, 16'(MOVE_LIMIT_MAX + 1), 16'd0, 16'd44);
    // Legal move, but the valve has never been homed.
    send_command(OP_MOVE, 8'd1, 8'(POS_LIMIT), 16'(MOVE_LIMIT_MAX), 16'd0, 16'd45);
    send_command(OP_HOME, 8'd2, 8'd0, 16'(HOME_LIMIT_MAX + 1), 16'd0, 16'd50);
    send_command(OP_HOME, 8'd3, 8'd0, 16'd0, 16'd0, 16'd60);
    send_command(OP_HOME, 8'd0, 8'd0, 16'd0, 16'd0, 16'd70);
    // Homing of the last valve starts at once; a move while it runs is refused.
    send_command(OP_HOME, 8'(VALVES), 8'd0, 16'd1, 16'h7FFF, 16'd100);
    send_command(OP_MOVE, 8'd0, 8'd0, 16'd1, 16'h8000, 16'd150);
    // A current equal to the limit is not an overcurrent; the tick wraps the
    // position from zero to the top.
    send_command(OP_CONTROL, 8'd0, 8'd0, 16'd0, 16'd1, 16'd400);
    send_command(OP_CONTROL, 8'd0, 8'd0, 16'd0, 16'h7FFF, 16'd401);
    send_command(OP_SPARE, 8'd0, 8'd0, 16'd0, 16'h7FFF, 16'd402);
    clock_ms = 16'd402;
    wait_for_status();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: period = 16'd1;
        1: begin
          period = 16'hFFFF;
          send_idle_pct = 52;
          recv_idle_pct = 31;
        end
        2: begin
          period = 16'($urandom_range(2, 400));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        default: period = 16'(TICK_RESET);
      endcase
      write_tick_period(period);
      // Hold the status side off for a long stretch so the block backs up.
      if (ph == 2) stall_left = STALL_CYCLES;
      mark = words_sent;
      while (words_sent - mark < PHASE_WORDS) begin
        case ($urandom_range(9))
          0, 1, 2:    home_valve($urandom_range(1, VALVES));
          3, 4, 5, 6: move_valve($urandom_range(1, VALVES));
          default: begin
            n = $urandom_range(1, 4);
            repeat (n)
              send_command(2'($urandom_range(3)),
                           ($urandom_range(1)) ? 8'($urandom_range(VALVES + 1)) : 8'($urandom),
                           8'($urandom), 16'($urandom), 16'($urandom),
                           ($urandom_range(1)) ? advance_ms() : 16'($urandom));
          end
        endcase
        // A job still running is ended by a sustained overcurrent, so the next
        // sequence starts from idle.
        n = 0;
        while (sb.mode != MODE_IDLE && n < 20) begin
          send_command(OP_CONTROL, 8'($urandom), 8'($urandom), 16'($urandom), 16'h7FFF,
                       advance_ms());
          n++;
        end
      end
      wait_for_status();
    end

    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // This bound lies far beyond the length of the whole run.
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/vps_pkg.sv
hw/rtl/vps_step.sv
hw/rtl/vps_skid.sv
hw/rtl/valve_position_sequencer_core.sv
tb/sv/testbench.sv
